### rtl/u16u8_pkg.sv
// Shared types, constants and UTF-8 encoding helpers for the UTF-16 to UTF-8 transcoder.
// Used by the front, queue, back and top-level modules; depends on nothing.
package u16u8_pkg;

  localparam int CP_W          = 21;  // code point width
  localparam int CNT_W         = 17;  // output byte count / capacity register width
  localparam int SUM_W         = 21;  // width for count plus code point lengths and clamp
  localparam int MAX_CAPACITY  = 65536;
  localparam int QUEUE_DEPTH   = 4;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 32;

  localparam logic [CNT_W-1:0] CAP_RESET = 17'h10000;

  // register indexes
  localparam logic REG_LSB_FIRST    = 1'b0;
  localparam logic REG_OUT_CAPACITY = 1'b1;

  localparam logic [CP_W-1:0] CP_SUPP_BASE = 21'h10000;
  localparam logic [CP_W-1:0] CP_MAX_1B    = 21'h00007F;
  localparam logic [CP_W-1:0] CP_MAX_2B    = 21'h0007FF;
  localparam logic [CP_W-1:0] CP_MAX_3B    = 21'h00FFFF;

  localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;  // 0xD800..0xDBFF
  localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;  // 0xDC00..0xDFFF

  localparam logic [7:0] LEAD_2B = 8'hC0;
  localparam logic [7:0] LEAD_3B = 8'hE0;
  localparam logic [7:0] LEAD_4B = 8'hF0;
  localparam logic [7:0] CONT_B  = 8'h80;

  // One queued request: up to two code points to encode, then an optional full status.
  typedef struct packed {
    logic [CP_W-1:0] cp0;
    logic [CP_W-1:0] cp1;
    logic [1:0]      ncp;
    logic            full;
  } u16u8_rec_t;

  typedef struct packed {
    logic       push;
    u16u8_rec_t rec;
  } u16u8_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } u16u8_qstat_t;

  function automatic logic [2:0] utf8_len(input logic [CP_W-1:0] cp);
    logic [2:0] n;
    if (cp <= CP_MAX_1B) begin
      n = 3'd1;
    end else if (cp <= CP_MAX_2B) begin
      n = 3'd2;
    end else if (cp <= CP_MAX_3B) begin
      n = 3'd3;
    end else begin
      n = 3'd4;
    end
    return n;
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] cp,
                                           input logic [2:0] len,
                                           input logic [1:0] idx);
    logic [7:0] b;
    b = 8'h00;
    unique case (len)
      3'd1: b = {1'b0, cp[6:0]};
      3'd2: begin
        if (idx == 2'd0) b = LEAD_2B | {3'b000, cp[10:6]};
        else             b = CONT_B  | {2'b00, cp[5:0]};
      end
      3'd3: begin
        case (idx)
          2'd0:    b = LEAD_3B | {4'b0000, cp[15:12]};
          2'd1:    b = CONT_B  | {2'b00, cp[11:6]};
          default: b = CONT_B  | {2'b00, cp[5:0]};
        endcase
      end
      default: begin
        case (idx)
          2'd0:    b = LEAD_4B | {5'b00000, cp[20:18]};
          2'd1:    b = CONT_B  | {2'b00, cp[17:12]};
          2'd2:    b = CONT_B  | {2'b00, cp[11:6]};
          default: b = CONT_B  | {2'b00, cp[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

### rtl/utf16_to_utf8_transcoder_core.sv
// Top level of the UTF-16 to UTF-8 transcoder: configuration registers and block wiring.
// Depends on u16u8_pkg, u16u8_front, u16u8_queue and u16u8_back.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_stall    in_byte_first, in_byte_second,
//                                              in_stream_start, in_stream_end
//   out      source     out_valid / out_stall  out_byte, out_byte_valid,
//                                              out_run_last, out_buffer_full
//   cfg      APB slave  psel/penable/pwrite    paddr, pwdata, prdata, pready
//
// The front end takes one code unit per cycle while the request queue has room; a unit
// turns into 0 to 6 results. The back end sends one result per cycle from its output
// register while out_stall is low, so an item gives one result per UTF-8 byte or full status
// (1 for an ASCII unit, 2 or 3 for other BMP units, 4 for a surrogate pair, up to 6 when
// a held surrogate is flushed ahead of a 3-byte unit).
// Synchronous active-low reset clears the held surrogate, byte count, stop latch, the queue
// and the output valid flag, and loads the register reset values.
// A stall on the output holds the current result; the front keeps accepting until the
// queue of QUEUE_DEPTH requests fills, then raises in_stall.
module utf16_to_utf8_transcoder_core #(
  parameter int MAX_CAPACITY = u16u8_pkg::MAX_CAPACITY,
  parameter int QUEUE_DEPTH  = u16u8_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_byte_first,
  input  logic [7:0]                       in_byte_second,
  input  logic                             in_stream_start,
  input  logic                             in_stream_end,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [7:0]                       out_byte,
  output logic                             out_byte_valid,
  output logic                             out_run_last,
  output logic                             out_buffer_full,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [u16u8_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [u16u8_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [u16u8_pkg::CFG_DATA_W-1:0] prdata,
  output logic                             pready
);

  logic                           le_r;
  logic [u16u8_pkg::CNT_W-1:0]    cap_r;
  logic                           cfg_wr, accept, pop;
  u16u8_pkg::u16u8_push_t         push;
  u16u8_pkg::u16u8_rec_t          head;
  u16u8_pkg::u16u8_qstat_t        stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // register index sits at paddr[2]: one word per register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      le_r  <= 1'b1;
      cap_r <= u16u8_pkg::CAP_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        u16u8_pkg::REG_LSB_FIRST: le_r  <= pwdata[0];
        default:                  cap_r <= pwdata[u16u8_pkg::CNT_W-1:0];
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      u16u8_pkg::REG_LSB_FIRST:
        prdata = {{(u16u8_pkg::CFG_DATA_W-1){1'b0}}, le_r};
      default:
        prdata = {{(u16u8_pkg::CFG_DATA_W-u16u8_pkg::CNT_W){1'b0}}, cap_r};
    endcase
  end

  // hold off new units only when the queue cannot take another request
  assign in_stall = stat.full;
  assign accept   = in_valid && !in_stall;

  u16u8_front #(
    .MAX_CAPACITY(MAX_CAPACITY)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .byte_first   (in_byte_first),
    .byte_second  (in_byte_second),
    .stream_start (in_stream_start),
    .stream_end   (in_stream_end),
    .lsb_first    (le_r),
    .out_capacity (cap_r),
    .push_o       (push)
  );

  u16u8_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push_i(push),
    .pop   (pop),
    .head  (head),
    .stat  (stat)
  );

  u16u8_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .stat           (stat),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_run_last   (out_run_last),
    .out_buffer_full(out_buffer_full)
  );

endmodule

### rtl/u16u8_front.sv
// Front end: accepts code units, pairs surrogates, checks capacity and queues encode requests.
// Depends on u16u8_pkg.
module u16u8_front #(
  parameter int MAX_CAPACITY = u16u8_pkg::MAX_CAPACITY
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [7:0]                  byte_first,
  input  logic [7:0]                  byte_second,
  input  logic                        stream_start,
  input  logic                        stream_end,
  input  logic                        lsb_first,
  input  logic [u16u8_pkg::CNT_W-1:0] out_capacity,
  output u16u8_pkg::u16u8_push_t      push_o
);

  localparam int SW = u16u8_pkg::SUM_W;
  localparam logic [SW-1:0] MAX_CAP = SW'(MAX_CAPACITY);

  logic [15:0]                  held_r, held_nxt;
  logic                         held_valid_r, held_valid_nxt;
  logic [u16u8_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic                         stopped_r, stopped_nxt;

  logic [15:0]                  held_e;
  logic                         held_valid_e, stopped_e;
  logic [u16u8_pkg::CNT_W-1:0]  count_e;
  logic [15:0]                  w;
  logic                         is_low, is_high, pair;
  logic                         a_vld, b_vld, fit_a, fit_b;
  logic [u16u8_pkg::CP_W-1:0]   cp_a, cp_b;
  logic [SW-1:0]                cap_e, sum_a, sum_b, base_b;
  u16u8_pkg::u16u8_rec_t        rec;

  always_comb begin
    // stream start clears everything before the unit is looked at
    held_e       = stream_start ? 16'h0000 : held_r;
    held_valid_e = stream_start ? 1'b0 : held_valid_r;
    count_e      = stream_start ? '0 : count_r;
    stopped_e    = stream_start ? 1'b0 : stopped_r;

    w       = lsb_first ? {byte_second, byte_first} : {byte_first, byte_second};
    is_low  = (w[15:10] == u16u8_pkg::LOW_SURR_TAG);
    is_high = (w[15:10] == u16u8_pkg::HIGH_SURR_TAG);
    pair    = held_valid_e && is_low;

    cap_e = ({{(SW-u16u8_pkg::CNT_W){1'b0}}, out_capacity} > MAX_CAP) ?
            MAX_CAP : {{(SW-u16u8_pkg::CNT_W){1'b0}}, out_capacity};

    a_vld = held_valid_e;
    cp_a  = pair ? (u16u8_pkg::CP_SUPP_BASE + {1'b0, held_e[9:0], w[9:0]})
                 : {5'b00000, held_e};
    b_vld = !pair && (w != 16'h0000) && !(is_high && !stream_end);
    cp_b  = {5'b00000, w};

    sum_a  = {{(SW-u16u8_pkg::CNT_W){1'b0}}, count_e}
             + {{(SW-3){1'b0}}, u16u8_pkg::utf8_len(cp_a)};
    fit_a  = sum_a < cap_e;
    base_b = (a_vld && fit_a) ? sum_a : {{(SW-u16u8_pkg::CNT_W){1'b0}}, count_e};
    sum_b  = base_b + {{(SW-3){1'b0}}, u16u8_pkg::utf8_len(cp_b)};
    fit_b  = sum_b < cap_e;

    rec.cp0  = cp_a;
    rec.cp1  = cp_b;
    rec.ncp  = 2'd0;
    rec.full = 1'b0;

    held_nxt       = held_e;
    held_valid_nxt = held_valid_e;
    count_nxt      = count_e;
    stopped_nxt    = stopped_e;

    if (!stopped_e) begin
      if (a_vld) begin
        held_nxt       = 16'h0000;
        held_valid_nxt = 1'b0;
        if (!fit_a) begin
          rec.full    = 1'b1;
          stopped_nxt = 1'b1;
        end else begin
          rec.ncp   = 2'd1;
          count_nxt = sum_a[u16u8_pkg::CNT_W-1:0];
          if (b_vld) begin
            if (fit_b) begin
              rec.ncp   = 2'd2;
              count_nxt = sum_b[u16u8_pkg::CNT_W-1:0];
            end else begin
              rec.full    = 1'b1;
              stopped_nxt = 1'b1;
            end
          end
        end
      end else if (b_vld) begin
        rec.cp0 = cp_b;
        if (fit_b) begin
          rec.ncp   = 2'd1;
          count_nxt = sum_b[u16u8_pkg::CNT_W-1:0];
        end else begin
          rec.full    = 1'b1;
          stopped_nxt = 1'b1;
        end
      end
      // a new high surrogate waits for its partner unless the stream ends here or output has stopped
      if (!pair && !stopped_nxt && is_high && !stream_end) begin
        held_nxt       = w;
        held_valid_nxt = 1'b1;
      end
    end

    push_o.push = accept && ((rec.ncp != 2'd0) || rec.full);
    push_o.rec  = rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r       <= 16'h0000;
      held_valid_r <= 1'b0;
      count_r      <= '0;
      stopped_r    <= 1'b0;
    end else if (accept) begin
      held_r       <= held_nxt;
      held_valid_r <= held_valid_nxt;
      count_r      <= count_nxt;
      stopped_r    <= stopped_nxt;
    end
  end

endmodule

### rtl/u16u8_queue.sv
// Short request queue between front and back ends.
// Depends on u16u8_pkg.
module u16u8_queue #(
  parameter int DEPTH = u16u8_pkg::QUEUE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  u16u8_pkg::u16u8_push_t  push_i,
  input  logic                    pop,
  output u16u8_pkg::u16u8_rec_t   head,
  output u16u8_pkg::u16u8_qstat_t stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  u16u8_pkg::u16u8_rec_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  always_comb begin
    do_push    = push_i.push && (cnt_r != FULL_CNT);
    do_pop     = pop && (cnt_r != '0);
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
    head       = mem_r[rd_ptr_r];
    stat.full  = (cnt_r == FULL_CNT);
    stat.empty = (cnt_r == '0);
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_i.rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

### rtl/u16u8_back.sv
// Back end: expands requests into UTF-8 bytes in the output register, one result per unstalled cycle.
// Depends on u16u8_pkg.
module u16u8_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  u16u8_pkg::u16u8_rec_t   head,
  input  u16u8_pkg::u16u8_qstat_t stat,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [7:0]              out_byte,
  output logic                    out_byte_valid,
  output logic                    out_run_last,
  output logic                    out_buffer_full
);

  logic [1:0] cpi_r, cpi_nxt;
  logic [1:0] bi_r, bi_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       bvld_r, bvld_nxt, last_r, last_nxt, full_r, full_nxt;

  logic [u16u8_pkg::CP_W-1:0] cur_cp;
  logic [2:0]                 len;
  logic                       load, in_data, cp_done, done;

  always_comb begin
    load    = !stat.empty && (!valid_r || !out_stall);
    cur_cp  = cpi_r[0] ? head.cp1 : head.cp0;
    len     = u16u8_pkg::utf8_len(cur_cp);
    in_data = cpi_r < head.ncp;
    cp_done = ({1'b0, bi_r} + 3'd1) == len;

    cpi_nxt  = cpi_r;
    bi_nxt   = bi_r;
    done     = 1'b0;
    byte_nxt = u16u8_pkg::utf8_byte(cur_cp, len, bi_r);
    bvld_nxt = 1'b1;
    full_nxt = 1'b0;

    if (in_data) begin
      if (cp_done) begin
        bi_nxt = 2'd0;
        if ((cpi_r + 2'd1) < head.ncp || head.full) begin
          cpi_nxt = cpi_r + 2'd1;
        end else begin
          done = 1'b1;
        end
      end else begin
        bi_nxt = bi_r + 2'd1;
      end
    end else begin
      // full status closes the request
      byte_nxt = 8'h00;
      bvld_nxt = 1'b0;
      full_nxt = 1'b1;
      done     = 1'b1;
    end
    last_nxt = done;
    if (done) begin
      cpi_nxt = 2'd0;
      bi_nxt  = 2'd0;
    end

    pop       = load && done;
    valid_nxt = load ? 1'b1 : (valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cpi_r   <= 2'd0;
      bi_r    <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      if (load) begin
        cpi_r <= cpi_nxt;
        bi_r  <= bi_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= byte_nxt;
      bvld_r <= bvld_nxt;
      last_r <= last_nxt;
      full_r <= full_nxt;
    end
  end

  assign out_valid       = valid_r;
  assign out_byte        = byte_r;
  assign out_byte_valid  = bvld_r;
  assign out_run_last    = last_r;
  assign out_buffer_full = full_r;

endmodule
